FILE: hdl/sfsf_pkg.sv
// Shared types, constants and command/status structs for the sieve factorizer.
package sfsf_pkg;
	localparam int LIMIT = 65536;
	localparam int PRIME_SLOTS = 8192;
	localparam int MAX_RESULTS = 16;
	localparam int VAL_W = $clog2(LIMIT);
	localparam int IDX_W = $clog2(PRIME_SLOTS);
	localparam int CNT_W = $clog2(PRIME_SLOTS + 1);
	localparam int LPF_W = VAL_W;
	localparam int RES_W = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_OOR  = 2'd2;

	localparam logic ACT_FACTOR = 1'b0;
	localparam logic ACT_PRIME  = 1'b1;

	typedef enum logic [3:0] {
		S_CLR, S_SCAN_RD, S_SCAN_CHK, S_MARK_RD, S_MARK_CHK,
		S_IDLE, S_LKP_RD, S_LKP_WAIT, S_DIV, S_EMIT, S_EMIT_WAIT
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic scan_init;
		logic scan_rd;
		logic scan_step;
		logic scan_prime;
		logic mark_rd;
		logic mark_step;
		logic mark_write;
		logic load_item;
		logic lpf_rd;
		logic div_start;
		logic div_step;
		logic take_quot;
		logic out_load;
		logic out_use_list;
		logic out_special;
		logic [1:0] out_status;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic scan_done;
		logic entry_zero;
		logic mark_done;
		logic mark_skip;
		logic div_done;
		logic val_one;
		logic res_full;
		logic act;
		logic val_zero;
		logic val_unit;
		logic idx_oor;
	} sts_t;
endpackage

FILE: hdl/sfsf_ram.sv
// Generic single-port RAM with registered read.
module sfsf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

FILE: hdl/sfsf_datapath.sv
// Datapath: sieve counters, tables, restoring divider and result register.
module sfsf_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sfsf_pkg::cmd_t       cmd,
	output sfsf_pkg::sts_t       sts,
	input  logic                 action,
	input  logic [15:0]          value,
	input  logic [12:0]          index,
	output logic [15:0]          factor,
	output logic                 last,
	output logic [1:0]           status
);
	import sfsf_pkg::*;

	logic [VAL_W-1:0] n_q, m_q, clr_q;
	logic [CNT_W-1:0] pcnt_q;
	logic             act_q;
	logic [15:0]      val_q;
	logic [12:0]      idx_q;
	logic [RES_W-1:0] res_q;
	logic [VAL_W-1:0] cur_q, p_q, quo_q;
	logic [VAL_W:0]   rem_q;
	logic [$clog2(VAL_W+1)-1:0] dcnt_q;
	logic [VAL_W-1:0] lpf_addr, lpf_wdata, lpf_rdata;
	logic             lpf_we;
	logic [IDX_W-1:0] prm_addr;
	logic [15:0]      prm_wdata, prm_rdata;
	logic             prm_we;
	logic [2*VAL_W-1:0] sq;
	logic [VAL_W:0]   m_next;
	logic [VAL_W:0]   rem_sh;

	assign sq = {{VAL_W{1'b0}}, n_q} * {{VAL_W{1'b0}}, n_q};
	assign m_next = {1'b0, m_q} + {1'b0, n_q};

	always_comb begin
		lpf_we = 1'b0;
		lpf_addr = '0;
		lpf_wdata = '0;
		if (cmd.clr_step) begin
			lpf_we = 1'b1;
			lpf_addr = clr_q;
		end else if (cmd.scan_prime) begin
			lpf_we = 1'b1;
			lpf_addr = n_q;
			lpf_wdata = n_q;
		end else if (cmd.mark_write) begin
			lpf_we = 1'b1;
			lpf_addr = m_q;
			lpf_wdata = n_q;
		end else if (cmd.scan_step) begin
			lpf_addr = VAL_W'(n_q + 1'b1);
		end else if (cmd.scan_rd) begin
			lpf_addr = n_q;
		end else if (cmd.mark_rd) begin
			lpf_addr = m_q;
		end else if (cmd.lpf_rd) begin
			lpf_addr = cur_q;
		end
	end

	always_comb begin
		prm_we = cmd.scan_prime && (pcnt_q < CNT_W'(PRIME_SLOTS));
		prm_addr = prm_we ? pcnt_q[IDX_W-1:0] : idx_q[IDX_W-1:0];
		prm_wdata = 16'(n_q);
	end

	sfsf_ram #(.WIDTH(LPF_W), .DEPTH(LIMIT)) u_lpf (
		.clk(clk), .we(lpf_we), .addr(lpf_addr), .wdata(lpf_wdata), .rdata(lpf_rdata)
	);
	sfsf_ram #(.WIDTH(16), .DEPTH(PRIME_SLOTS)) u_prm (
		.clk(clk), .we(prm_we), .addr(prm_addr), .wdata(prm_wdata), .rdata(prm_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			n_q <= '0;
			m_q <= '0;
			pcnt_q <= '0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.scan_init) begin
				n_q <= VAL_W'(2);
				pcnt_q <= '0;
			end else if (cmd.scan_prime) begin
				if (pcnt_q < CNT_W'(PRIME_SLOTS)) pcnt_q <= pcnt_q + 1'b1;
				m_q <= sq[VAL_W-1:0];
			end else if (cmd.scan_step) begin
				n_q <= n_q + 1'b1;
			end else if (cmd.mark_step) begin
				m_q <= m_next[VAL_W-1:0];
			end
		end
	end

	assign rem_sh = {rem_q[VAL_W-1:0], quo_q[VAL_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			act_q <= action;
			val_q <= value;
			idx_q <= index;
			cur_q <= VAL_W'(value);
			res_q <= '0;
		end
		if (cmd.div_start) begin
			p_q <= lpf_rdata;
			quo_q <= cur_q;
			rem_q <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + 1'b1;
			if (rem_sh >= {1'b0, p_q}) begin
				rem_q <= rem_sh - {1'b0, p_q};
				quo_q <= {quo_q[VAL_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[VAL_W-2:0], 1'b0};
			end
		end
		if (cmd.take_quot) begin
			cur_q <= quo_q;
			res_q <= res_q + 1'b1;
		end
		if (cmd.out_load) begin
			if (cmd.out_special) begin
				factor <= '0;
				last <= 1'b1;
			end else if (cmd.out_use_list) begin
				factor <= prm_rdata;
				last <= 1'b1;
			end else begin
				factor <= 16'(p_q);
				last <= (quo_q <= VAL_W'(1)) || (res_q == RES_W'(MAX_RESULTS - 1));
			end
			status <= cmd.out_status;
		end
	end

	always_comb begin
		sts.clr_done = (clr_q == VAL_W'(LIMIT - 1));
		sts.scan_done = (n_q == VAL_W'(LIMIT - 1));
		sts.entry_zero = (lpf_rdata == '0);
		sts.mark_done = (m_next > (VAL_W+1)'(LIMIT - 1));
		sts.mark_skip = (sq >= (2*VAL_W)'(LIMIT));
		sts.div_done = (dcnt_q == ($clog2(VAL_W+1))'(VAL_W - 1));
		sts.val_one = (cur_q <= VAL_W'(1));
		sts.res_full = (res_q == RES_W'(MAX_RESULTS));
		sts.act = act_q;
		sts.val_zero = (val_q == 16'd0) || (17'(val_q) >= 17'(LIMIT));
		sts.val_unit = (val_q == 16'd1);
		sts.idx_oor = (14'(idx_q) >= 14'(pcnt_q)) || (14'(idx_q) >= 14'(PRIME_SLOTS));
	end
endmodule

FILE: hdl/sfsf_ctrl.sv
// Controller state machine for sieve build and item service.
module sfsf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  sfsf_pkg::sts_t  sts,
	output sfsf_pkg::cmd_t  cmd
);
	import sfsf_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR: if (sts.clr_done) state_d = S_SCAN_RD;
			S_SCAN_RD: state_d = S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (sts.entry_zero) state_d = S_MARK_RD;
				else if (sts.scan_done) state_d = S_IDLE;
				else state_d = S_SCAN_CHK;
			end
			S_MARK_RD: begin
				if (sts.mark_skip) state_d = sts.scan_done ? S_IDLE : S_SCAN_CHK;
				else state_d = S_MARK_CHK;
			end
			S_MARK_CHK: begin
				if (sts.mark_done) state_d = sts.scan_done ? S_IDLE : S_SCAN_RD;
				else state_d = S_MARK_RD;
			end
			S_IDLE: if (in_valid) state_d = S_LKP_RD;
			S_LKP_RD: state_d = S_LKP_WAIT;
			S_LKP_WAIT: state_d = (sts.act || sts.val_zero || sts.val_unit) ? S_EMIT : S_DIV;
			S_DIV: if (sts.div_done) state_d = S_EMIT;
			S_EMIT: state_d = S_EMIT_WAIT;
			S_EMIT_WAIT: begin
				if (!out_stall) begin
					if (sts.act || sts.val_zero || sts.val_unit || sts.val_one || sts.res_full)
						state_d = S_IDLE;
					else
						state_d = S_LKP_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = (state_q != S_IDLE);
		out_valid = (state_q == S_EMIT_WAIT);
		unique case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) cmd.scan_init = 1'b1;
			end
			S_SCAN_RD: cmd.scan_rd = 1'b1;
			S_SCAN_CHK: begin
				if (sts.entry_zero) cmd.scan_prime = 1'b1;
				else if (!sts.scan_done) cmd.scan_step = 1'b1;
			end
			S_MARK_RD: begin
				if (sts.mark_skip) begin
					if (!sts.scan_done) cmd.scan_step = 1'b1;
				end else begin
					cmd.mark_rd = 1'b1;
				end
			end
			S_MARK_CHK: begin
				cmd.mark_write = sts.entry_zero;
				if (sts.mark_done) begin
					if (!sts.scan_done) cmd.scan_step = 1'b1;
				end else begin
					cmd.mark_step = 1'b1;
				end
			end
			S_IDLE: cmd.load_item = in_valid;
			S_LKP_RD: cmd.lpf_rd = 1'b1;
			S_LKP_WAIT: cmd.div_start = 1'b1;
			S_DIV: cmd.div_step = 1'b1;
			S_EMIT: begin
				cmd.out_load = 1'b1;
				if (sts.act) begin
					cmd.out_use_list = !sts.idx_oor;
					cmd.out_special = sts.idx_oor;
					cmd.out_status = sts.idx_oor ? ST_OOR : ST_OK;
				end else if (sts.val_zero) begin
					cmd.out_special = 1'b1;
					cmd.out_status = ST_OOR;
				end else if (sts.val_unit) begin
					cmd.out_special = 1'b1;
					cmd.out_status = ST_NONE;
				end else begin
					cmd.out_status = ST_OK;
					cmd.take_quot = 1'b1;
				end
			end
			S_EMIT_WAIT: ;
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
	a_emit_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |=> out_valid) else $error("result not shown");
`endif
endmodule

FILE: hdl/smallest_factor_sieve_factorizer_top.sv
// Top level of the smallest-prime-factor sieve factorizer.
// Use: after arst_n rises the block clears its factor table and runs
// the sieve, scanning each number and marking the multiples of each
// prime found; in_stall stays high until the tables are built.
// Input channel in_valid/in_stall carries action, value and index.
// Output channel out_valid/out_stall carries factor, last and status.
// A prime-at-index item gives one result.
// A factorize item gives one result per prime factor, up to MAX_RESULTS,
// each found by a table read plus a 16-step restoring divider.
// Items are served one at a time; the next is taken after the last
// result transfers. A stalled result holds its value until taken.
// Reset returns to the table clear and drops any item in flight.
module smallest_factor_sieve_factorizer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [15:0] value,
	input  logic [12:0] index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] factor,
	output logic        last,
	output logic [1:0]  status
);
	import sfsf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sfsf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);
	sfsf_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .action(action),
		.value(value), .index(index), .factor(factor), .last(last), .status(status)
	);
endmodule

FILE: sim/tb_smallest_factor_sieve_factorizer_top.sv
// Self-checking testbench for the sieve factorizer: factorize and prime-lookup transfers.
`timescale 1ns / 100ps

import sfsf_pkg::*;

class factor_scoreboard;
	logic [15:0] lpf_tbl [LIMIT];
	logic [15:0] primes [PRIME_SLOTS];
	int prime_total;
	logic [15:0] want_factor [$];
	logic want_last [$];
	logic [1:0] want_status [$];
	int errors;
	int results_seen;

	function new();
		int n;
		longint m;
		for (n = 0; n < LIMIT; n++) lpf_tbl[n] = 0;
		prime_total = 0;
		for (n = 2; n < LIMIT; n++) begin
			if (lpf_tbl[n] != 0) continue;
			lpf_tbl[n] = 16'(n);
			if (prime_total < PRIME_SLOTS) begin
				primes[prime_total] = 16'(n);
				prime_total++;
			end
			for (m = longint'(n) * n; m < LIMIT; m += n)
				if (lpf_tbl[m] == 0) lpf_tbl[m] = 16'(n);
		end
		errors = 0;
		results_seen = 0;
	endfunction

	function void push(logic [15:0] f, logic l, logic [1:0] s);
		want_factor = {want_factor, f};
		want_last = {want_last, l};
		want_status = {want_status, s};
	endfunction

	function void note_item(logic act, logic [15:0] val, logic [12:0] idx);
		int v, p, cnt;
		if (act == ACT_PRIME) begin
			if (idx >= prime_total) push(16'd0, 1'b1, ST_OOR);
			else push(primes[idx], 1'b1, ST_OK);
			return;
		end
		if (val == 0) begin
			push(16'd0, 1'b1, ST_OOR);
			return;
		end
		if (val == 1) begin
			push(16'd0, 1'b1, ST_NONE);
			return;
		end
		v = val;
		cnt = 0;
		while (v > 1 && cnt < MAX_RESULTS) begin
			p = lpf_tbl[v];
			v = v / p;
			push(p[15:0], (v <= 1 || cnt == MAX_RESULTS - 1), ST_OK);
			cnt++;
		end
	endfunction

	function void check_result(logic [15:0] f, logic l, logic [1:0] s);
		logic [15:0] ef;
		logic el;
		logic [1:0] es;
		results_seen++;
		if (want_factor.size() == 0) begin
			$error("unexpected result factor=%0d last=%0d status=%0d", f, l, s);
			errors++;
			return;
		end
		ef = want_factor.pop_front();
		el = want_last.pop_front();
		es = want_status.pop_front();
		if (f !== ef) begin
			$error("factor: expected %0d, actual %0d", ef, f);
			errors++;
		end
		if (l !== el) begin
			$error("last: expected %0d, actual %0d", el, l);
			errors++;
		end
		if (s !== es) begin
			$error("status: expected %0d, actual %0d", es, s);
			errors++;
		end
	endfunction

	function int pending();
		return want_factor.size();
	endfunction
endclass

module tb_smallest_factor_sieve_factorizer_top;
	localparam int CYCLE_LIMIT = 5_000_000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic action;
	logic [15:0] value;
	logic [12:0] index;
	logic out_valid;
	logic out_stall;
	logic [15:0] factor;
	logic last;
	logic [1:0] status;

	factor_scoreboard sb;
	int cycles;
	int items_sent;
	bit calm;
	bit hold_rx;
	int n_fact, n_prime;

	smallest_factor_sieve_factorizer_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .value(value), .index(index),
		.out_valid(out_valid), .out_stall(out_stall),
		.factor(factor), .last(last), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		sb = new();
		calm = 1'b0;
		hold_rx = 1'b0;
		in_valid = 1'b0;
		action = ACT_FACTOR;
		value = '0;
		index = '0;
		out_stall = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
		if (out_valid && !out_stall)
			sb.check_result(factor, last, status);
	end

	// receiver: random stall bursts, or a long hold-off when requested
	initial begin
		int k;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				out_stall = 1'b1;
				for (k = 0; k < 600; k++) @(negedge clk);
				out_stall = 1'b0;
				hold_rx = 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	task automatic send(logic act, logic [15:0] val, logic [12:0] idx);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid = 1'b1;
		action = act;
		value = val;
		index = idx;
		do @(posedge clk); while (in_stall);
		sb.note_item(act, val, idx);
		items_sent++;
		if (act == ACT_PRIME) n_prime++; else n_fact++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 16'(1 << $urandom_range(1, 15));
			1: return 16'($urandom_range(0, 3));
			2: return 16'(sb.primes[$urandom_range(0, sb.prime_total - 1)]);
			3: return 16'(3 ** $urandom_range(1, 10));
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int i;
		logic [15:0] v;
		cycles = 0;
		items_sent = 0;
		n_fact = 0;
		n_prime = 0;
		@(posedge arst_n);
		@(negedge clk);
		send(ACT_FACTOR, 16'd0, 13'd0);
		send(ACT_FACTOR, 16'd1, 13'h1fff);
		send(ACT_FACTOR, 16'd2, 13'd0);
		send(ACT_FACTOR, 16'd3, 13'd0);
		send(ACT_FACTOR, 16'd4, 13'd0);
		send(ACT_FACTOR, 16'd32768, 13'd0);
		send(ACT_FACTOR, 16'd65535, 13'd0);
		send(ACT_FACTOR, 16'd65521, 13'd0);
		send(ACT_FACTOR, 16'd65534, 13'd0);
		send(ACT_FACTOR, 16'd30030, 13'd0);
		send(ACT_FACTOR, 16'd59049, 13'd0);
		send(ACT_PRIME, 16'hffff, 13'd0);
		send(ACT_PRIME, 16'd0, 13'd1);
		send(ACT_PRIME, 16'd0, 13'(sb.prime_total - 1));
		send(ACT_PRIME, 16'd0, 13'(sb.prime_total));
		send(ACT_PRIME, 16'd0, 13'h1fff);
		send(ACT_PRIME, 16'd0, 13'h1555);
		send(ACT_PRIME, 16'd0, 13'h0aaa);
		drain();
		hold_rx = 1'b1;
		for (i = 0; i < 8; i++) send(ACT_PRIME, 16'd0, 13'($urandom_range(0, 8191)));
		drain();
		for (i = 0; i < 290; i++) begin
			if (i == 250) begin
				drain();
				calm = 1'b1;
			end
			if ($urandom_range(0, 2) == 0) begin
				v = 16'($urandom);
				send(ACT_PRIME, v, 13'($urandom_range(0, 8191)));
			end else
				send(ACT_FACTOR, pick_value(), 13'($urandom));
		end
		drain();
		repeat (50) @(negedge clk);
		$display("covered %0d transfers in: %0d factorize, %0d prime lookup", items_sent,
			n_fact, n_prime);
		$display("checked %0d results, including stall hold-off and drained pause",
			sb.results_seen);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
